### rtl/fmprc_pkg.sv
// ----------------------------------------------------------------------------
// fmprc_pkg: shared types and constants
// Codes, flag layout and controller/datapath signal groups of the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmprc_pkg;

  localparam int unsigned NOBJ = 6;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic FUNC_CLASSIFY = 1'b0;
  localparam logic FUNC_WRITE    = 1'b1;

  localparam logic [2:0] TGT_ACTION = 3'd6;

  localparam logic [3:0] WSEL_TYPE  = 4'd0;
  localparam logic [3:0] WSEL_MASK  = 4'd1;
  localparam logic [3:0] WSEL_VAL0  = 4'd2;
  localparam logic [3:0] WSEL_FLAGS = 4'd0;
  localparam logic [3:0] WSEL_MAC   = 4'd1;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam int unsigned FL_VALID = 0;
  localparam int unsigned FL_FWD   = 1;
  localparam int unsigned FL_RW    = 2;
  localparam int unsigned FL_INV   = 3;

  typedef enum logic [2:0] {
    OT_ANY    = 3'd0,
    OT_SINGLE = 3'd1,
    OT_PREFIX = 3'd2,
    OT_RANGE  = 3'd3,
    OT_GROUP  = 3'd4
  } obj_type_e;

  typedef struct packed {
    logic clear;
    logic wr;
    logic start;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic miss;
  } sts_t;

endpackage

### rtl/fmprc_if.sv
// ----------------------------------------------------------------------------
// fmprc_if: classifier channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fmprc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  slot;
  logic [2:0]  target;
  logic [3:0]  word_sel;
  logic [47:0] wdata;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] vlan;

  modport source (output valid, func, slot, target, word_sel, wdata, src_addr, dst_addr,
                  protocol, src_port, dst_port, vlan, input ready);
  modport sink (input valid, func, slot, target, word_sel, wdata, src_addr, dst_addr,
                protocol, src_port, dst_port, vlan, output ready);
endinterface

interface fmprc_res_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [5:0]  hit_slot;
  logic        forward;
  logic        rewrite_mac;
  logic [47:0] new_mac;

  modport source (output valid, matched, hit_slot, forward, rewrite_mac, new_mac,
                  input ready);
  modport sink (input valid, matched, hit_slot, forward, rewrite_mac, new_mac,
                output ready);
endinterface

### rtl/first_match_packet_rule_classifier_core.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier_core: ordered ACL classifier
// Writes rule words into slot memories and finds the first matching rule.
//
//   channel  dir  words
//   req_i    in   rule word write or packet classify request
//   res_o    out  one result word per classify, none per write
//
// A classify walks one match object per cycle through the object memories,
// six per slot. After reset a clearing pass zeroes the rule flags of all
// slots; no request is taken during it. One request is in flight at a time;
// a stalled result holds until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_match_packet_rule_classifier_core #(
  parameter int unsigned RULES      = 64,
  parameter int unsigned GROUP_SIZE = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fmprc_req_if.sink    req_i,
  fmprc_res_if.source  res_o
);
  import fmprc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fmprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_func_i   (req_i.func),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fmprc_dp #(
    .RULES      (RULES),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .slot_i        (req_i.slot),
    .target_i      (req_i.target),
    .word_sel_i    (req_i.word_sel),
    .wdata_i       (req_i.wdata),
    .src_addr_i    (req_i.src_addr),
    .dst_addr_i    (req_i.dst_addr),
    .protocol_i    (req_i.protocol),
    .src_port_i    (req_i.src_port),
    .dst_port_i    (req_i.dst_port),
    .vlan_i        (req_i.vlan),
    .matched_o     (res_o.matched),
    .hit_slot_o    (res_o.hit_slot),
    .forward_o     (res_o.forward),
    .rewrite_mac_o (res_o.rewrite_mac),
    .new_mac_o     (res_o.new_mac)
  );

endmodule

### rtl/fmprc_ctrl.sv
// ----------------------------------------------------------------------------
// fmprc_ctrl: classifier controller
// Sequences the flag clear, rule writes, the slot scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmprc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_func_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fmprc_pkg::cmd_t    cmd_o,
  input  fmprc_pkg::sts_t    sts_i
);
  import fmprc_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MAC   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clear_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i && in_func_i == FUNC_CLASSIFY) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit) state_d = ST_MAC;
        else if (sts_i.miss) state_d = ST_OUT;
      end
      ST_MAC:  state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  assign cmd_o.clear = (state_q == ST_CLEAR);
  assign cmd_o.wr    = in_ready_o && in_valid_i && (in_func_i == FUNC_WRITE);
  assign cmd_o.start = in_ready_o && in_valid_i && (in_func_i == FUNC_CLASSIFY);
  assign cmd_o.scan  = (state_q == ST_SCAN);

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and result valid together");
  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_i.hit || sts_i.miss) |-> state_q == ST_SCAN) else $error("scan status outside scan");
  a_hit_to_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.hit |=> state_q == ST_MAC) else $error("hit did not fetch mac");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == ST_SCAN) else $error("classify did not start scan");
`endif

endmodule

### rtl/fmprc_dp.sv
// ----------------------------------------------------------------------------
// fmprc_dp: classifier datapath
// Rule memories, key register, one-object-per-cycle match pipeline, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmprc_dp #(
  parameter int unsigned RULES      = 64,
  parameter int unsigned GROUP_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmprc_pkg::cmd_t    cmd_i,
  output fmprc_pkg::sts_t    sts_o,
  input  logic [5:0]         slot_i,
  input  logic [2:0]         target_i,
  input  logic [3:0]         word_sel_i,
  input  logic [47:0]        wdata_i,
  input  logic [31:0]        src_addr_i,
  input  logic [31:0]        dst_addr_i,
  input  logic [7:0]         protocol_i,
  input  logic [15:0]        src_port_i,
  input  logic [15:0]        dst_port_i,
  input  logic [15:0]        vlan_i,
  output logic               matched_o,
  output logic [5:0]         hit_slot_o,
  output logic               forward_o,
  output logic               rewrite_mac_o,
  output logic [47:0]        new_mac_o
);
  import fmprc_pkg::*;

  localparam int unsigned ROWS  = RULES * NOBJ;
  localparam int unsigned RW    = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam logic [RW-1:0]    LAST_RULE = RW'(RULES - 1);
  localparam logic [2:0]       LAST_OBJ  = 3'(NOBJ - 1);

  logic [2:0]  type_mem [ROWS];
  logic [31:0] mask_mem [ROWS];
  logic [8:0]  flag_mem [RULES];
  logic [47:0] mac_mem  [RULES];

  logic            slot_ok;
  logic [RW-1:0]   wslot;
  logic [ROW_W-1:0] wrow;
  logic [5:0]      widx;
  logic            wval_ok;
  logic            wr_obj;
  logic            wr_act;

  assign slot_ok = (11'(slot_i) < 11'(RULES));
  assign wslot   = RW'(slot_i);
  assign wrow    = ROW_W'({wslot, 2'b00}) + ROW_W'({wslot, 1'b0}) + ROW_W'(target_i);
  assign widx    = {2'b00, word_sel_i} - 6'(WSEL_VAL0);
  assign wval_ok = (word_sel_i >= WSEL_VAL0) && (widx < 6'(GROUP_SIZE));
  assign wr_obj  = cmd_i.wr && slot_ok && (32'(target_i) < NOBJ);
  assign wr_act  = cmd_i.wr && slot_ok && (target_i == TGT_ACTION);

  logic [RW-1:0]    r_q;
  logic [2:0]       k_q;
  logic [ROW_W-1:0] addr_q;
  logic             run_q;
  logic             v_q;
  logic [RW-1:0]    r1_q;
  logic [2:0]       k1_q;
  logic [RW-1:0]    clr_q;
  logic [RW-1:0]    hit_r_q;

  logic [2:0]  type_q;
  logic [31:0] mask_q;
  logic [31:0] val_q [GROUP_SIZE];
  logic [8:0]  flag_q;
  logic [47:0] mac_q;

  always_ff @(posedge clk_i) begin
    if (wr_obj && word_sel_i == WSEL_TYPE) type_mem[wrow] <= wdata_i[2:0];
    if (wr_obj && word_sel_i == WSEL_MASK) mask_mem[wrow] <= wdata_i[31:0];
    if (cmd_i.clear) flag_mem[clr_q] <= '0;
    else if (wr_act && word_sel_i == WSEL_FLAGS) flag_mem[wslot] <= wdata_i[8:0];
    if (wr_act && word_sel_i == WSEL_MAC) mac_mem[wslot] <= wdata_i;
    type_q <= type_mem[addr_q];
    mask_q <= mask_mem[addr_q];
    flag_q <= flag_mem[r_q];
    mac_q  <= mac_mem[hit_r_q];
  end

  for (genvar g = 0; g < GROUP_SIZE; g++) begin : gen_val
    logic [31:0] val_mem [ROWS];
    always_ff @(posedge clk_i) begin
      if (wr_obj && wval_ok && widx == 6'(g)) val_mem[wrow] <= wdata_i[31:0];
      val_q[g] <= val_mem[addr_q];
    end
  end

  logic [31:0] key_q [NOBJ];
  logic        l4;
  assign l4 = (protocol_i == PROTO_TCP) || (protocol_i == PROTO_UDP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q[0] <= src_addr_i;
      key_q[1] <= dst_addr_i;
      key_q[2] <= l4 ? {16'h0, src_port_i} : 32'h0;
      key_q[3] <= l4 ? {16'h0, dst_port_i} : 32'h0;
      key_q[4] <= {24'h0, protocol_i};
      key_q[5] <= {16'h0, vlan_i};
    end
  end

  logic [31:0] x;
  logic        grp_hit;
  logic        obj_match;
  logic        obj_ok;
  logic        acc_q, acc_d;
  logic [5:0]  inv_bits;
  logic        rule_end;

  assign x        = key_q[k1_q];
  assign inv_bits = flag_q[FL_INV +: NOBJ];

  always_comb begin
    grp_hit = 1'b0;
    for (int g = 0; g < GROUP_SIZE; g++) begin
      if (val_q[g] == x) grp_hit = 1'b1;
    end
  end

  always_comb begin
    if (mask_q == ALL_ONES) begin
      obj_match = 1'b1;
    end else if (mask_q != 32'h0 && (mask_q & x) != x) begin
      obj_match = 1'b0;
    end else begin
      unique case (type_q)
        OT_ANY:    obj_match = 1'b1;
        OT_SINGLE: obj_match = (val_q[0] == 32'h0) || (val_q[0] == x);
        OT_PREFIX: obj_match = (val_q[0] & val_q[1]) == (x & val_q[1]);
        OT_RANGE:  obj_match = (val_q[0] <= x) && (val_q[1] >= x);
        OT_GROUP:  obj_match = grp_hit;
        default:   obj_match = 1'b0;
      endcase
    end
  end

  assign obj_ok   = (obj_match != inv_bits[k1_q]);
  assign acc_d    = ((k1_q == 3'd0) ? flag_q[FL_VALID] : acc_q) & obj_ok;
  assign rule_end = cmd_i.scan && v_q && (k1_q == LAST_OBJ);

  assign sts_o.hit        = rule_end && acc_d;
  assign sts_o.miss       = rule_end && !acc_d && (r1_q == LAST_RULE);
  assign sts_o.clear_done = cmd_i.clear && (clr_q == LAST_RULE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      v_q   <= 1'b0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + RW'(1);
      if (cmd_i.start) begin
        run_q <= 1'b1;
        v_q   <= 1'b0;
      end else if (sts_o.hit) begin
        run_q <= 1'b0;
        v_q   <= 1'b0;
      end else if (cmd_i.scan) begin
        v_q <= run_q;
        if (run_q && r_q == LAST_RULE && k_q == LAST_OBJ) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q    <= '0;
      k_q    <= '0;
      addr_q <= '0;
    end else if (cmd_i.scan && run_q) begin
      addr_q <= addr_q + ROW_W'(1);
      if (k_q == LAST_OBJ) begin
        k_q <= '0;
        r_q <= r_q + RW'(1);
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
    r1_q <= r_q;
    k1_q <= k_q;
    if (v_q) acc_q <= acc_d;
  end

  logic res_matched_q, res_fwd_q, res_rw_q;
  logic [5:0] res_slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_matched_q <= 1'b0;
      res_slot_q    <= '0;
      res_fwd_q     <= 1'b0;
      res_rw_q      <= 1'b0;
    end else if (sts_o.hit) begin
      res_matched_q <= 1'b1;
      res_slot_q    <= 6'(r1_q);
      res_fwd_q     <= flag_q[FL_FWD];
      res_rw_q      <= flag_q[FL_FWD] & flag_q[FL_RW];
      hit_r_q       <= r1_q;
    end
  end

  assign matched_o     = res_matched_q;
  assign hit_slot_o    = res_slot_q;
  assign forward_o     = res_fwd_q;
  assign rewrite_mac_o = res_rw_q;
  assign new_mac_o     = res_rw_q ? mac_q : 48'h0;

endmodule

### dv/first_match_packet_rule_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier_core_tb: self-checking classifier bench
// Writes rule words and classifies packets over the request channel. Every
// classify verdict is checked field by field against the verdict of its
// directed row or else a local predictor of the rule table. Directed words
// lead, then random rules, packets and noise in several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_match_packet_rule_classifier_core_tb;
  import fmprc_pkg::*;

  localparam int unsigned NRULE = 64;
  localparam int unsigned NGRP  = 8;
  localparam int unsigned NRAND = 2000;
  localparam logic [2:0] TGT_SIP   = 3'd0;
  localparam logic [2:0] TGT_SPORT = 3'd2;
  localparam logic [2:0] TGT_PROTO = 3'd4;
  localparam logic [2:0] TGT_VLAN  = 3'd5;
  localparam logic [2:0] TGT_NONE  = 3'd7;
  localparam logic [2:0] OT_BAD    = 3'd7;
  localparam logic [8:0] FLG_VALID = 9'h001;
  localparam logic [8:0] FLG_FWD   = 9'h002;
  localparam logic [8:0] FLG_RW    = 9'h004;

  typedef struct {
    logic        func;
    logic [5:0]  slot;
    logic [2:0]  target;
    logic [3:0]  wsel;
    logic [47:0] wdata;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] vlan;
  } req_word_t;

  typedef struct {
    logic        matched;
    logic [5:0]  hit_slot;
    logic        fwd;
    logic        rw;
    logic [47:0] mac;
  } verdict_t;

  typedef struct {
    req_word_t w;
    bit        typed;
    verdict_t  v;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  fmprc_req_if req ();
  fmprc_res_if res ();

  first_match_packet_rule_classifier_core #(
    .RULES     (NRULE),
    .GROUP_SIZE(NGRP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res)
  );

  logic [2:0]  typ_mem [NRULE*NOBJ];
  logic [31:0] msk_mem [NRULE*NOBJ];
  logic [31:0] val_mem [NRULE*NOBJ*NGRP];
  logic [8:0]  flag_mem[NRULE];
  logic [47:0] mac_mem [NRULE];
  bit          wr_typ  [NRULE*NOBJ];
  bit          wr_msk  [NRULE*NOBJ];
  bit          wr_val  [NRULE*NOBJ*NGRP];
  bit          wr_mac  [NRULE];
  logic [31:0] pool    [NOBJ][8];

  verdict_t verdict_q[$];
  int       errors;
  int       sent;
  int       idle_pct;
  int       stall_pct;
  bit       hold_arm;
  bit       hold_done;
  int       hold_left;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [31:0] fit(int k, logic [31:0] x);
    if (k < 2) return x;
    if (k == 4) return {24'd0, x[7:0]};
    return {16'd0, x[15:0]};
  endfunction

  function automatic bit obj_hit(int idx, logic [31:0] x);
    logic [31:0] m;
    int b;
    m = msk_mem[idx];
    b = idx * NGRP;
    if (m == ALL_ONES) return 1'b1;
    if (m != 0 && (m & x) != x) return 1'b0;
    case (typ_mem[idx])
      OT_ANY:    return 1'b1;
      OT_SINGLE: return val_mem[b] == 0 || val_mem[b] == x;
      OT_PREFIX: return (val_mem[b] & val_mem[b+1]) == (x & val_mem[b+1]);
      OT_RANGE:  return val_mem[b] <= x && val_mem[b+1] >= x;
      OT_GROUP: begin
        for (int i = 0; i < NGRP; i++) if (val_mem[b+i] == x) return 1'b1;
        return 1'b0;
      end
      default:   return 1'b0;
    endcase
  endfunction

  function automatic verdict_t classify(req_word_t w);
    verdict_t v;
    logic [31:0] key[NOBJ];
    bit hit;
    bit l4;
    v = '{1'b0, 6'd0, 1'b0, 1'b0, 48'd0};
    l4 = (w.proto == PROTO_TCP) || (w.proto == PROTO_UDP);
    key[0] = w.sip;
    key[1] = w.dip;
    key[2] = l4 ? {16'd0, w.sport} : 32'd0;
    key[3] = l4 ? {16'd0, w.dport} : 32'd0;
    key[4] = {24'd0, w.proto};
    key[5] = {16'd0, w.vlan};
    for (int r = 0; r < NRULE; r++) begin
      hit = flag_mem[r][FL_VALID];
      for (int k = 0; k < NOBJ; k++)
        if (hit && obj_hit(r * NOBJ + k, key[k]) == flag_mem[r][FL_INV+k]) hit = 1'b0;
      if (hit) begin
        v.matched  = 1'b1;
        v.hit_slot = r[5:0];
        v.fwd      = flag_mem[r][FL_FWD];
        v.rw       = flag_mem[r][FL_FWD] & flag_mem[r][FL_RW];
        v.mac      = v.rw ? mac_mem[r] : 48'd0;
        return v;
      end
    end
    return v;
  endfunction

  function automatic void store_word(req_word_t w);
    int idx;
    idx = w.slot * NOBJ + w.target;
    if (w.target < NOBJ) begin
      if (w.wsel == WSEL_TYPE) begin
        typ_mem[idx] = w.wdata[2:0];
        wr_typ[idx] = 1'b1;
      end else if (w.wsel == WSEL_MASK) begin
        msk_mem[idx] = w.wdata[31:0];
        wr_msk[idx] = 1'b1;
      end else if (w.wsel - WSEL_VAL0 < NGRP) begin
        val_mem[idx*NGRP + w.wsel - WSEL_VAL0] = w.wdata[31:0];
        wr_val[idx*NGRP + w.wsel - WSEL_VAL0] = 1'b1;
      end
    end else if (w.target == TGT_ACTION) begin
      if (w.wsel == WSEL_FLAGS) flag_mem[w.slot] = w.wdata[8:0];
      else if (w.wsel == WSEL_MAC) begin
        mac_mem[w.slot] = w.wdata;
        wr_mac[w.slot] = 1'b1;
      end
    end
  endfunction

  function automatic req_word_t wr(logic [5:0] s, logic [2:0] t, logic [3:0] ws,
                                   logic [47:0] d);
    req_word_t w;
    w = '{FUNC_WRITE, s, t, ws, d, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0};
    return w;
  endfunction

  function automatic req_word_t pkt(logic [31:0] si, logic [31:0] di, logic [7:0] pr,
                                    logic [15:0] sp, logic [15:0] dp, logic [15:0] vl);
    req_word_t w;
    w = '{FUNC_CLASSIFY, 6'($urandom), 3'($urandom), 4'($urandom),
          48'({$urandom, $urandom}), si, di, pr, sp, dp, vl};
    return w;
  endfunction

  function automatic bit slot_ready(int s);
    if (!wr_mac[s]) return 1'b0;
    for (int i = s * NOBJ; i < (s + 1) * NOBJ; i++) begin
      if (!wr_typ[i] || !wr_msk[i]) return 1'b0;
      for (int j = 0; j < NGRP; j++) if (!wr_val[i*NGRP+j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_mask(int k);
    int p;
    p = $urandom_range(9);
    if (p < 6) return 32'd0;
    if (p < 7) return ALL_ONES;
    return fit(k, pool[k][$urandom_range(7)] | $urandom);
  endfunction

  function automatic logic [31:0] rand_val(int k);
    int p;
    p = $urandom_range(9);
    if (p < 6) return pool[k][$urandom_range(7)];
    if (p < 8) return fit(k, pool[k][$urandom_range(7)] + $urandom_range(4) - 2);
    return fit(k, $urandom);
  endfunction

  function automatic logic [2:0] rand_type();
    return ($urandom_range(9) < 9) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
  endfunction

  task automatic send(input req_word_t w, input bit typed, input verdict_t tv);
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.func     <= w.func;
    req.slot     <= w.slot;
    req.target   <= w.target;
    req.word_sel <= w.wsel;
    req.wdata    <= w.wdata;
    req.src_addr <= w.sip;
    req.dst_addr <= w.dip;
    req.protocol <= w.proto;
    req.src_port <= w.sport;
    req.dst_port <= w.dport;
    req.vlan     <= w.vlan;
    do @(posedge clk_i); while (!req.ready);
    sent++;
    if (w.func == FUNC_CLASSIFY) verdict_q.push_back(typed ? tv : classify(w));
    else store_word(w);
  endtask

  task automatic put(input req_word_t w);
    verdict_t none;
    none = '{1'b0, 6'd0, 1'b0, 1'b0, 48'd0};
    send(w, 1'b0, none);
  endtask

  task automatic fill_slot(input int s, input bit rnd);
    int idx;
    for (int k = 0; k < NOBJ; k++) begin
      idx = s * NOBJ + k;
      if (!wr_typ[idx]) put(wr(6'(s), 3'(k), WSEL_TYPE, 48'(rnd ? rand_type() : OT_ANY)));
      if (!wr_msk[idx]) put(wr(6'(s), 3'(k), WSEL_MASK, 48'(rnd ? rand_mask(k) : 32'd0)));
      for (int j = 0; j < NGRP; j++)
        if (!wr_val[idx*NGRP+j])
          put(wr(6'(s), 3'(k), WSEL_VAL0 + 4'(j), 48'(rnd ? rand_val(k) : 32'd0)));
    end
    if (!wr_mac[s]) put(wr(6'(s), TGT_ACTION, WSEL_MAC, 48'({$urandom, $urandom})));
  endtask

  function automatic req_word_t rand_pkt(bit noise);
    req_word_t w;
    logic [31:0] f[NOBJ];
    int p;
    for (int k = 0; k < NOBJ; k++)
      f[k] = (!noise && $urandom_range(9) < 8) ? rand_val(k) : fit(k, $urandom);
    p = $urandom_range(9);
    if (!noise && p < 4) f[4] = 32'(PROTO_TCP);
    else if (!noise && p < 7) f[4] = 32'(PROTO_UDP);
    w = pkt(f[0], f[1], f[4][7:0], f[2][15:0], f[3][15:0], f[5][15:0]);
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict m=%0b slot=%0d fwd=%0b rw=%0b mac=%h", $time,
                 res.matched, res.hit_slot, res.forward, res.rewrite_mac, res.new_mac);
      end else begin
        e = verdict_q.pop_front();
        if (res.matched !== e.matched || res.hit_slot !== e.hit_slot ||
            res.forward !== e.fwd || res.rewrite_mac !== e.rw || res.new_mac !== e.mac) begin
          errors++;
          $display("%0t: mismatch exp m=%0b slot=%0d fwd=%0b rw=%0b mac=%h", $time,
                   e.matched, e.hit_slot, e.fwd, e.rw, e.mac);
          $display("%0t:          got m=%0b slot=%0d fwd=%0b rw=%0b mac=%h", $time,
                   res.matched, res.hit_slot, res.forward, res.rewrite_mac, res.new_mac);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("first_match_packet_rule_classifier_core_tb: FAIL");
    $finish;
  end

  initial begin
    dir_row_t    plan[$];
    verdict_t    miss;
    verdict_t    top;
    logic [47:0] ones;
    req_word_t   w;
    int          s;
    int          p;
    int          k;
    int          base;
    logic [8:0]  fl;

    ones = '1;
    miss = '{1'b0, 6'd0, 1'b0, 1'b0, 48'd0};
    top  = '{1'b1, 6'd63, 1'b1, 1'b1, ones};
    errors = 0;
    sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_arm = 0;
    hold_done = 0;
    hold_left = 0;
    for (int i = 0; i < NRULE; i++) flag_mem[i] = '0;
    for (int j = 0; j < NOBJ; j++)
      for (int i = 0; i < 8; i++) pool[j][i] = fit(j, $urandom);
    rst_ni = 1'b0;
    req.valid <= 1'b0;
    req.func <= FUNC_CLASSIFY;
    req.slot <= '0;
    req.target <= '0;
    req.word_sel <= '0;
    req.wdata <= '0;
    req.src_addr <= '0;
    req.dst_addr <= '0;
    req.protocol <= '0;
    req.src_port <= '0;
    req.dst_port <= '0;
    req.vlan <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_slot(0, 1'b0);
    fill_slot(63, 1'b0);

    plan.push_back('{pkt(32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0), 1'b1, miss});
    plan.push_back('{pkt('1, '1, '1, '1, '1, '1), 1'b1, miss});
    plan.push_back('{wr(6'd63, TGT_ACTION, WSEL_MAC, ones), 1'b0, miss});
    plan.push_back('{wr(6'd63, TGT_ACTION, WSEL_FLAGS, 48'(FLG_VALID | FLG_FWD | FLG_RW)),
                     1'b0, miss});
    plan.push_back('{pkt('1, '1, '1, '1, '1, '1), 1'b1, top});
    plan.push_back('{wr(6'd0, TGT_PROTO, WSEL_TYPE, 48'(OT_SINGLE)), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_PROTO, WSEL_VAL0, 48'(PROTO_TCP)), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_ACTION, WSEL_FLAGS, 48'(FLG_VALID | FLG_FWD)), 1'b0, miss});
    plan.push_back('{pkt(32'd0, 32'd0, PROTO_TCP, '1, '1, 16'd0), 1'b1,
                     '{1'b1, 6'd0, 1'b1, 1'b0, 48'd0}});
    plan.push_back('{pkt(32'd0, 32'd0, PROTO_UDP, '1, '1, 16'd0), 1'b1, top});
    plan.push_back('{wr(6'd0, TGT_ACTION, WSEL_FLAGS,
                        48'(FLG_VALID | (9'd1 << (FL_INV + 4)))), 1'b0, miss});
    plan.push_back('{pkt(32'd0, 32'd0, PROTO_UDP, 16'd0, 16'd0, 16'd0), 1'b1,
                     '{1'b1, 6'd0, 1'b0, 1'b0, 48'd0}});
    plan.push_back('{wr(6'd0, TGT_SIP, WSEL_TYPE, 48'(OT_BAD)), 1'b0, miss});
    plan.push_back('{pkt(32'd0, 32'd0, PROTO_UDP, 16'd0, 16'd0, 16'd0), 1'b1, top});
    plan.push_back('{wr(6'd0, TGT_SIP, WSEL_TYPE, 48'(OT_PREFIX)), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_SIP, WSEL_VAL0 + 4'd1, 48'hffff_0000), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_SIP, WSEL_VAL0, 48'h0a0b_0000), 1'b0, miss});
    plan.push_back('{pkt(32'h0a0b_1234, 32'd0, PROTO_UDP, 16'd0, 16'd0, 16'd0), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_SPORT, WSEL_TYPE, 48'(OT_RANGE)), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_SPORT, WSEL_VAL0 + 4'd1, 48'd1000), 1'b0, miss});
    plan.push_back('{pkt(32'h0a0b_ffff, 32'd0, 8'd1, '1, '1, 16'd0), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_VLAN, WSEL_TYPE, 48'(OT_GROUP)), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_VLAN, WSEL_VAL0 + 4'd7, 48'd100), 1'b0, miss});
    plan.push_back('{pkt(32'h0a0b_0001, 32'd0, 8'd1, 16'd0, 16'd0, 16'd100), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_NONE, WSEL_TYPE, ones), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_SIP, 4'd15, ones), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_ACTION, 4'd2, ones), 1'b0, miss});
    plan.push_back('{wr(6'd0, TGT_SIP, WSEL_MASK, 48'(ALL_ONES)), 1'b0, miss});
    plan.push_back('{pkt(32'h1234_5678, 32'd0, 8'd1, 16'd0, 16'd0, 16'd7), 1'b0, miss});
    foreach (plan[i]) send(plan[i].w, plan[i].typed, plan[i].v);

    base = sent;
    while (sent - base < NRAND) begin
      case ((sent - base) * 4 / NRAND)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 65;
        end
        default: begin
          idle_pct = 27;
          stall_pct = 27;
        end
      endcase
      if (sent - base > NRAND / 8) hold_arm = 1'b1;
      s = ($urandom_range(9) < 9) ? $urandom_range(7) : $urandom_range(63);
      k = $urandom_range(5);
      p = $urandom_range(99);
      if (p < 40) begin
        put(rand_pkt(1'b0));
      end else if (p < 48) begin
        put(rand_pkt(1'b1));
      end else if (p < 75) begin
        w = wr(6'(s), 3'(k), 4'($urandom_range(9)), 48'({$urandom, $urandom}));
        if (w.wsel == WSEL_TYPE) w.wdata = 48'(rand_type());
        else if (w.wsel == WSEL_MASK && $urandom_range(3) != 0) w.wdata = 48'(rand_mask(k));
        else if ($urandom_range(4) != 0) w.wdata = 48'(rand_val(k));
        put(w);
      end else if (p < 85) begin
        fl = 9'($urandom);
        fl[FL_VALID] = ($urandom_range(3) != 0);
        if (fl[FL_VALID] && !slot_ready(s)) fill_slot(s, 1'b1);
        put(wr(6'(s), TGT_ACTION, WSEL_FLAGS,
               48'({$urandom, $urandom}) & ~48'h1ff | 48'(fl)));
      end else if (p < 92) begin
        put(wr(6'(s), TGT_ACTION, WSEL_MAC, 48'({$urandom, $urandom})));
      end else if (p < 96) begin
        put(wr(6'(s), TGT_NONE, 4'($urandom), 48'({$urandom, $urandom})));
      end else begin
        put(wr(6'(s), 3'($urandom_range(6)), 4'($urandom_range(10, 15)),
               48'({$urandom, $urandom})));
      end
    end
    req.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (6 * NRULE + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("first_match_packet_rule_classifier_core_tb: PASS");
    end else begin
      $display("first_match_packet_rule_classifier_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### first_match_packet_rule_classifier_core.f
rtl/fmprc_pkg.sv
rtl/fmprc_if.sv
rtl/fmprc_ctrl.sv
rtl/fmprc_dp.sv
rtl/first_match_packet_rule_classifier_core.sv
dv/first_match_packet_rule_classifier_core_tb.sv
